// ===== hdl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants of the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int WORD_W        = 32;
    localparam int OCC_W         = 5;
    localparam int DEPTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        CMD_ADD_FRONT = 2'd0,
        CMD_ADD_REAR  = 2'd1,
        CMD_DEL_FRONT = 2'd2,
        CMD_DEL_REAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // what the back end does with the slot memory
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        status_t           status;
        logic [OCC_W-1:0]  occupancy;
    } deq_ctl_t;

    localparam int CTL_W = $bits(deq_ctl_t);

endpackage

// ===== hdl/deq_cmd_if.sv =====
// ----------------------------------------------------------------------------
// deq_cmd_if
// command channel: valid/ready with command code and push word
// ----------------------------------------------------------------------------
interface deq_cmd_if;

    logic                                    valid;
    logic                                    ready;
    deq_pkg::cmd_t                           cmd;
    logic signed [deq_pkg::WORD_W-1:0]       push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);

endinterface

// ===== hdl/deq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// deq_rsp_if
// response channel: valid/ready with popped word, status and occupancy
// ----------------------------------------------------------------------------
interface deq_rsp_if;

    logic                                    valid;
    logic                                    ready;
    logic signed [deq_pkg::WORD_W-1:0]       pop_value;
    deq_pkg::status_t                        status;
    logic [deq_pkg::OCC_W-1:0]               occupancy;

    modport source (output valid, output pop_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input pop_value, input status, input occupancy,
                    output ready);

endinterface

// ===== hdl/deq_front.sv =====
// ----------------------------------------------------------------------------
// deq_front
// takes commands, checks full/empty, keeps front pointer and count,
// and hands a slot operation to the back end
// ----------------------------------------------------------------------------
module deq_front #(
    parameter int  DEPTH = deq_pkg::DEPTH_DEFAULT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    deq_cmd_if.sink                     req,
    output logic                        op_valid,
    input  logic                        op_ready,
    output deq_pkg::deq_ctl_t           op_ctl,
    output logic [AW-1:0]               op_addr,
    output logic [deq_pkg::WORD_W-1:0]  op_word
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;

    logic          accept;
    logic          is_full;
    logic          ring_empty;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW:0]   wr_sum;
    logic [AW:0]   rd_sum;
    logic [AW-1:0] rear_wr;
    logic [AW-1:0] rear_rd;

    assign accept    = req.valid && op_ready;
    assign req.ready = op_ready;
    assign op_valid  = req.valid;
    assign op_word   = req.push_value;

    assign is_full    = (count_reg == CW'(DEPTH));
    assign ring_empty = (count_reg == '0);

    // ring arithmetic, sums stay below twice the depth
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign wr_sum    = {1'b0, front_reg} + (AW+1)'(count_reg);
    assign rd_sum    = wr_sum - 1'b1;
    assign rear_wr   = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH))
                                                  : AW'(wr_sum);
    assign rear_rd   = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH))
                                                  : AW'(rd_sum);

    always_comb
    begin
        front_next    = front_reg;
        count_next    = count_reg;
        op_ctl.kind   = OP_NONE;
        op_ctl.status = ST_OK;
        op_addr       = front_reg;
        unique case (req.cmd)
            CMD_ADD_FRONT:
            begin
                if (is_full)
                begin
                    op_ctl.status = ST_FULL;
                end
                else
                begin
                    op_ctl.kind = OP_WRITE;
                    op_addr     = front_dec;
                    front_next  = front_dec;
                    count_next  = count_reg + 1'b1;
                end
            end
            CMD_ADD_REAR:
            begin
                if (is_full)
                begin
                    op_ctl.status = ST_FULL;
                end
                else
                begin
                    op_ctl.kind = OP_WRITE;
                    op_addr     = rear_wr;
                    count_next  = count_reg + 1'b1;
                end
            end
            CMD_DEL_FRONT:
            begin
                if (ring_empty)
                begin
                    op_ctl.status = ST_EMPTY;
                end
                else
                begin
                    op_ctl.kind = OP_READ;
                    op_addr     = front_reg;
                    front_next  = front_inc;
                    count_next  = count_reg - 1'b1;
                end
            end
            CMD_DEL_REAR:
            begin
                if (ring_empty)
                begin
                    op_ctl.status = ST_EMPTY;
                end
                else
                begin
                    op_ctl.kind = OP_READ;
                    op_addr     = rear_rd;
                    count_next  = count_reg - 1'b1;
                end
            end
            default:
            begin
                op_ctl.kind = OP_NONE;
            end
        endcase
        op_ctl.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/deq_queue.sv =====
// ----------------------------------------------------------------------------
// deq_queue
// short first-in first-out buffer between front and back end
// ----------------------------------------------------------------------------
module deq_queue #(
    parameter int W     = deq_pkg::CTL_W,
    parameter int DEPTH = deq_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  logic [W-1:0]  push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output logic [W-1:0]  pop_data
);
    import deq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (cnt_reg != CW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/deq_back.sv =====
// ----------------------------------------------------------------------------
// deq_back
// carries out slot writes and reads and holds the response register
// ----------------------------------------------------------------------------
module deq_back #(
    parameter int  DEPTH = deq_pkg::DEPTH_DEFAULT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        op_valid,
    output logic                        op_ready,
    input  deq_pkg::deq_ctl_t           op_ctl,
    input  logic [AW-1:0]               op_addr,
    input  logic [deq_pkg::WORD_W-1:0]  op_word,
    deq_rsp_if.source                   rsp
);
    import deq_pkg::*;

    logic [WORD_W-1:0] slot_mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    deq_ctl_t          ctl_reg;
    logic              out_valid_reg, out_valid_next;
    logic              take;

    assign op_ready = !out_valid_reg || rsp.ready;
    assign take     = op_valid && op_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // slot memory, at most one write per operation, read data registered
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (op_ctl.kind == OP_WRITE)
            begin
                slot_mem[op_addr] <= op_word;
            end
            rd_data_reg <= slot_mem[op_addr];
            ctl_reg     <= op_ctl;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.pop_value = (ctl_reg.kind == OP_READ) ? rd_data_reg : '0;
    assign rsp.status    = ctl_reg.status;
    assign rsp.occupancy = ctl_reg.occupancy;

endmodule

// ===== hdl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// double-ended queue of signed 32-bit words in a ring of DEPTH slots
// ----------------------------------------------------------------------------
//
//  channel   dir   words carried
//  -------   ---   -------------------------------------------------------
//  req       in    cmd (add front/rear, delete front/rear), push_value
//  rsp       out   pop_value, status (ok/empty/full), occupancy after cmd
//
//  one command word per cycle sustained while rsp is not stalled; a response
//  is valid after its command passes the queue entry and then the slot
//  memory read register
//  rst_n clears the front pointer, count, queue and response valid; the slot
//  memory is not cleared and needs no clearing pass
//  a stalled rsp fills the two-entry queue, after which req.ready drops
//
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    deq_cmd_if.sink     req,
    deq_rsp_if.source   rsp
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW = CTL_W + AW + WORD_W;

    // front end to queue
    logic              f_valid;
    logic              f_ready;
    deq_ctl_t          f_ctl;
    logic [AW-1:0]     f_addr;
    logic [WORD_W-1:0] f_word;

    // queue to back end
    logic              b_valid;
    logic              b_ready;
    logic [QW-1:0]     b_data;
    deq_ctl_t          b_ctl;
    logic [AW-1:0]     b_addr;
    logic [WORD_W-1:0] b_word;

    // pointer keeping and full/empty checks
    deq_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .op_valid (f_valid),
        .op_ready (f_ready),
        .op_ctl   (f_ctl),
        .op_addr  (f_addr),
        .op_word  (f_word)
    );

    // decouples command acceptance from response back-pressure
    deq_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_ctl, f_addr, f_word}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    assign {b_ctl, b_addr, b_word} = b_data;

    // slot memory and response register
    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (b_valid),
        .op_ready (b_ready),
        .op_ctl   (b_ctl),
        .op_addr  (b_addr),
        .op_word  (b_word),
        .rsp      (rsp)
    );

    // a failed command never writes the slot memory
    a_fail_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid && f_ctl.status != ST_OK) |-> (f_ctl.kind == OP_NONE))
        else $error("failed command issued a slot access");

    // a failed command returns a zero word
    a_fail_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.pop_value == '0))
        else $error("failed command returned a word");

    // a full error reports a full ring
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> (rsp.occupancy == OCC_W'(DEPTH)))
        else $error("full error with wrong occupancy");

    // an empty error reports an empty ring
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0))
        else $error("empty error with nonzero occupancy");

endmodule
